// ===== hw/rtl/sc2key_pkg.sv =====
// Shared types, scan code constants and the key lookup table of the scan code translator.
`timescale 1ns / 1ps

package sc2key_pkg;

    localparam int unsigned HALF_SIZE = 89;
    localparam int unsigned TABLE_DEPTH = 2 * HALF_SIZE;

    localparam logic [7:0] SC_PREFIX_E0   = 8'hE0;
    localparam logic [7:0] SC_PREFIX_E1   = 8'hE1;
    localparam logic [7:0] SC_LAST_KEY    = 8'h58;
    localparam logic [7:0] SC_KEYPAD_HOME = 8'h47;
    localparam logic [7:0] SC_CAPS        = 8'h3A;
    localparam logic [7:0] SC_NUM         = 8'h45;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
    localparam logic [7:0] SC_ALT_MAKE    = 8'h38;
    localparam logic [7:0] SC_ALT_BRK     = 8'hB8;
    localparam logic [7:0] SC_KP_SLASH    = 8'h35;
    localparam logic [7:0] SC_KP_ENTER    = 8'h1C;
    localparam logic [7:0] SC_F1          = 8'h3B;
    localparam logic [7:0] SC_F10         = 8'h44;
    localparam logic [7:0] SC_F11         = 8'h57;
    localparam logic [7:0] SC_F12         = 8'h58;
    localparam logic [7:0] SC_FKEY_SPLIT  = 8'h56;
    localparam logic [7:0] SC_ALT_FIRST   = 8'd30;

    localparam logic [7:0] FKEY_SHIFT_ADJ = 8'd25;
    localparam logic [7:0] FKEY_HIGH_ADJ  = 8'h2E;

    localparam logic [15:0] CHAR_SLASH = 16'h002F;
    localparam logic [15:0] CHAR_CR    = 16'h000D;
    localparam logic [15:0] CHAR_ZERO  = 16'h0030;
    localparam logic [15:0] CHAR_NINE  = 16'h0039;
    localparam logic [15:0] CHAR_LA    = 16'h0061;
    localparam logic [15:0] CHAR_LZ    = 16'h007A;
    localparam logic [15:0] CHAR_UA    = 16'h0041;
    localparam logic [15:0] CHAR_UZ    = 16'h005A;
    localparam logic [15:0] CTRL_LOWER_BASE = 16'h0060;
    localparam logic [15:0] CTRL_UPPER_BASE = 16'h0040;

    localparam logic [1:0] ALT_DIGITS_FULL = 2'd3;

    typedef struct packed {
        logic       prefix_seen;
        logic       caps_on;
        logic       num_on;
        logic [1:0] shift_bits;
        logic [1:0] ctrl_bits;
        logic [1:0] alt_bits;
        logic [1:0] alt_digit_count;
        logic [7:0] alt_code_accum;
    } t_kbd_state;

    typedef struct packed {
        logic        have;
        logic [15:0] key_word;
    } t_key_result;

    localparam t_kbd_state KBD_STATE_RESET = '{
        prefix_seen: 1'b0, caps_on: 1'b0, num_on: 1'b1, shift_bits: 2'b00,
        ctrl_bits: 2'b00, alt_bits: 2'b00, alt_digit_count: 2'b00,
        alt_code_accum: 8'h00
    };

    // Base half first, shifted or numeric half second.
    localparam logic [15:0] KEY_TABLE [0:TABLE_DEPTH-1] = '{
        16'h0000, 16'h001B, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
        16'h0037, 16'h0038, 16'h0039, 16'h0030, 16'h002D, 16'h003D, 16'h0008, 16'h0009,
        16'h0071, 16'h0077, 16'h0065, 16'h0072, 16'h0074, 16'h0079, 16'h0075, 16'h0069,
        16'h006F, 16'h0070, 16'h005B, 16'h005D, 16'h000D, 16'h0000, 16'h0061, 16'h0073,
        16'h0064, 16'h0066, 16'h0067, 16'h0068, 16'h006A, 16'h006B, 16'h006C, 16'h003B,
        16'h0027, 16'h0060, 16'h0000, 16'h005C, 16'h007A, 16'h0078, 16'h0063, 16'h0076,
        16'h0062, 16'h006E, 16'h006D, 16'h002C, 16'h002E, 16'h002F, 16'h0000, 16'h002A,
        16'h0000, 16'h0020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4700,
        16'h4800, 16'h4900, 16'h002D, 16'h4B00, 16'h4C00, 16'h4D00, 16'h002B, 16'h4F00,
        16'h5000, 16'h5100, 16'h0030, 16'h002E, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000,
        16'h0000, 16'h001B, 16'h0021, 16'h0040, 16'h0023, 16'h0024, 16'h0025, 16'h005E,
        16'h0026, 16'h002A, 16'h0028, 16'h0029, 16'h005F, 16'h002B, 16'h0008, 16'h0009,
        16'h0051, 16'h0057, 16'h0045, 16'h0052, 16'h0054, 16'h0059, 16'h0055, 16'h0049,
        16'h004F, 16'h0050, 16'h007B, 16'h007D, 16'h000D, 16'h0000, 16'h0041, 16'h0053,
        16'h0044, 16'h0046, 16'h0047, 16'h0048, 16'h004A, 16'h004B, 16'h004C, 16'h003A,
        16'h0022, 16'h007E, 16'h0000, 16'h007C, 16'h005A, 16'h0058, 16'h0043, 16'h0056,
        16'h0042, 16'h004E, 16'h004D, 16'h003C, 16'h003E, 16'h003F, 16'h0000, 16'h002A,
        16'h0000, 16'h0020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0037,
        16'h0038, 16'h0039, 16'h002D, 16'h0034, 16'h0035, 16'h0036, 16'h002B, 16'h0031,
        16'h0032, 16'h0033, 16'h0030, 16'h002E, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000
    };

endpackage

// ===== hw/rtl/scancode_to_key_translator.sv =====
// Top level of the set-1 scan code to key word translator.
`timescale 1ns / 1ps

// Takes one raw set-1 scan code byte per request and returns zero or one 16-bit key
// word: ASCII in the low byte, a control code for Ctrl with a letter, the byte typed by
// Alt-keypad entry, or in the high byte the extended key's scan code or an F-key code.
// Make and release codes that only change modifiers or lock state return nothing.
// A scan code is accepted every clock cycle while the output is not stalled; the
// input register and then the result register lie between accept and key word; a
// stalled output holds the translation logic, which then backs up into the input side.
module scancode_to_key_translator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] scan_code
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] key_word
);
    import sc2key_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_code;
    t_kbd_state  r_state;
    logic        r_out_valid;
    logic [15:0] r_out_word;
    t_kbd_state  n_state;
    t_key_result step_res;
    logic        advance;

    sc2key_xlate u_xlate (
        .i_code  (r_in_code),
        .i_state (r_state),
        .o_state (n_state),
        .o_result(step_res)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= KBD_STATE_RESET;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && step_res.have) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_code <= i_s_tdata;
        end
        if (advance && step_res.have) begin
            r_out_word <= step_res.key_word;
        end
    end

endmodule

// ===== hw/rtl/sc2key_xlate.sv =====
// Combinational translation of one scan code against the keyboard state.
`timescale 1ns / 1ps

module sc2key_xlate (
    input  logic [7:0]             i_code,
    input  sc2key_pkg::t_kbd_state i_state,
    output sc2key_pkg::t_kbd_state o_state,
    output sc2key_pkg::t_key_result o_result
);
    import sc2key_pkg::*;

    t_kbd_state  mod_st;
    t_kbd_state  nx;
    t_key_result res;
    logic        sh;
    logic        up;
    logic        in_range;
    logic [7:0]  base_idx;
    logic [7:0]  sel_idx;
    logic [7:0]  num_idx;
    logic [15:0] base_ent;
    logic [15:0] sel_ent;
    logic [15:0] num_ent;
    logic [7:0]  fkey_adj;
    logic [7:0]  fkey_code;
    logic [7:0]  accum_x10;

    always_comb begin
        mod_st = i_state;
        case (i_code)
            SC_CAPS:        mod_st.caps_on = ~i_state.caps_on;
            SC_NUM:         mod_st.num_on = ~i_state.num_on;
            SC_LSHIFT_MAKE: mod_st.shift_bits = i_state.shift_bits | 2'b01;
            SC_RSHIFT_MAKE: mod_st.shift_bits = i_state.shift_bits | 2'b10;
            SC_LSHIFT_BRK:  mod_st.shift_bits = i_state.shift_bits & 2'b10;
            SC_RSHIFT_BRK:  mod_st.shift_bits = i_state.shift_bits & 2'b01;
            SC_CTRL_MAKE:   mod_st.ctrl_bits = i_state.ctrl_bits | 2'b10;
            SC_CTRL_BRK:    mod_st.ctrl_bits = i_state.ctrl_bits & 2'b01;
            SC_ALT_MAKE:    mod_st.alt_bits = i_state.alt_bits | 2'b10;
            SC_ALT_BRK:     mod_st.alt_bits = i_state.alt_bits & 2'b01;
            default: begin
            end
        endcase

        sh = (mod_st.shift_bits != 2'b00) != mod_st.caps_on;
        up = (i_code < SC_KEYPAD_HOME) ? sh : mod_st.num_on;
        in_range = (i_code <= SC_LAST_KEY);
        base_idx = in_range ? i_code : 8'd0;
        num_idx  = base_idx + 8'(HALF_SIZE);
        sel_idx  = up ? num_idx : base_idx;
        base_ent = KEY_TABLE[base_idx];
        sel_ent  = KEY_TABLE[sel_idx];
        num_ent  = KEY_TABLE[num_idx];

        fkey_adj  = (i_code > SC_FKEY_SPLIT) ? (FKEY_HIGH_ADJ + {6'd0, up, 1'b0})
                                             : (up ? FKEY_SHIFT_ADJ : 8'd0);
        fkey_code = i_code + fkey_adj;
        accum_x10 = {i_state.alt_code_accum[4:0], 3'b000}
                  + {i_state.alt_code_accum[6:0], 1'b0};

        nx = i_state;
        res.have = 1'b0;
        res.key_word = 16'h0000;

        if (i_state.prefix_seen) begin
            case (i_code)
                SC_CTRL_MAKE: nx.ctrl_bits = i_state.ctrl_bits | 2'b01;
                SC_CTRL_BRK:  nx.ctrl_bits = i_state.ctrl_bits & 2'b10;
                SC_ALT_MAKE:  nx.alt_bits = i_state.alt_bits | 2'b01;
                SC_ALT_BRK:   nx.alt_bits = i_state.alt_bits & 2'b10;
                SC_KP_SLASH: begin
                    res.have = 1'b1;
                    res.key_word = CHAR_SLASH;
                end
                SC_KP_ENTER: begin
                    res.have = 1'b1;
                    res.key_word = CHAR_CR;
                end
                default: begin
                    if (!i_code[7] && i_code != SC_LSHIFT_MAKE) begin
                        res.have = 1'b1;
                        res.key_word = {i_code, 8'h00};
                    end
                end
            endcase
        end else begin
            nx = mod_st;
            if (i_code != SC_PREFIX_E0 && i_code != SC_PREFIX_E1 && in_range) begin
                if (base_ent != 16'h0000) begin
                    if (mod_st.alt_bits != 2'b00) begin
                        if (i_code > SC_ALT_FIRST && num_ent >= CHAR_ZERO
                                && num_ent <= CHAR_NINE) begin
                            nx.alt_digit_count = mod_st.alt_digit_count + 2'd1;
                            nx.alt_code_accum = accum_x10 + {4'd0, num_ent[3:0]};
                        end
                    end else begin
                        res.have = 1'b1;
                        if (mod_st.ctrl_bits != 2'b00 && sel_ent >= CHAR_LA
                                && sel_ent <= CHAR_LZ) begin
                            res.key_word = sel_ent - CTRL_LOWER_BASE;
                        end else if (mod_st.ctrl_bits != 2'b00 && sel_ent >= CHAR_UA
                                && sel_ent <= CHAR_UZ) begin
                            res.key_word = sel_ent - CTRL_UPPER_BASE;
                        end else begin
                            res.key_word = sel_ent;
                        end
                    end
                end else if (i_code inside {[SC_F1:SC_F10], SC_F11, SC_F12}) begin
                    res.have = 1'b1;
                    res.key_word = {fkey_code, 8'h00};
                end
            end
        end

        nx.prefix_seen = (i_code == SC_PREFIX_E0);

        if (nx.alt_digit_count == ALT_DIGITS_FULL
                || (nx.alt_digit_count != 2'd0 && nx.alt_bits == 2'b00)) begin
            res.have = 1'b1;
            res.key_word = {8'h00, nx.alt_code_accum};
            nx.alt_digit_count = 2'd0;
            nx.alt_code_accum = 8'h00;
        end

        o_state = nx;
        o_result = res;
    end

endmodule

// ===== dv/tb_scancode_to_key_translator.sv =====
// Self-checking testbench of the set-1 scan code to key word translator.
`timescale 1ns / 1ps

module tb_scancode_to_key_translator;

    localparam int unsigned KEYMAP_HALF = 89;
    localparam logic [7:0] SC_E0        = 8'hE0;
    localparam logic [7:0] SC_E1        = 8'hE1;
    localparam logic [7:0] SC_MAX_KEY   = 8'h58;
    localparam logic [7:0] SC_KEYPAD    = 8'h47;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_NUM       = 8'h45;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_CTRL      = 8'h1D;
    localparam logic [7:0] SC_ALT       = 8'h38;
    localparam logic [7:0] SC_KP_SLASH  = 8'h35;
    localparam logic [7:0] SC_KP_ENTER  = 8'h1C;
    localparam logic [7:0] SC_F1        = 8'h3B;
    localparam logic [7:0] SC_F10       = 8'h44;
    localparam logic [7:0] SC_F11       = 8'h57;
    localparam logic [7:0] SC_F12       = 8'h58;
    localparam logic [7:0] BREAK_BIT    = 8'h80;
    localparam logic [7:0] ALT_MIN_CODE = 8'd30;
    localparam logic [7:0] FKEY_SHIFTED = 8'd25;
    localparam logic [7:0] FKEY_HIGH    = 8'h2E;
    localparam logic [15:0] KEY_CR      = 16'h000D;
    localparam logic [15:0] KEY_SLASH   = 16'h002F;

    localparam int LONG_HOLD   = 300;
    localparam int PHASE_CODES = 630;
    localparam int DRAIN_LIMIT = 20000;

    localparam logic [15:0] KEYMAP [2*KEYMAP_HALF] = '{
        16'h0000, 16'h001B, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
        16'h0037, 16'h0038, 16'h0039, 16'h0030, 16'h002D, 16'h003D, 16'h0008, 16'h0009,
        16'h0071, 16'h0077, 16'h0065, 16'h0072, 16'h0074, 16'h0079, 16'h0075, 16'h0069,
        16'h006F, 16'h0070, 16'h005B, 16'h005D, 16'h000D, 16'h0000, 16'h0061, 16'h0073,
        16'h0064, 16'h0066, 16'h0067, 16'h0068, 16'h006A, 16'h006B, 16'h006C, 16'h003B,
        16'h0027, 16'h0060, 16'h0000, 16'h005C, 16'h007A, 16'h0078, 16'h0063, 16'h0076,
        16'h0062, 16'h006E, 16'h006D, 16'h002C, 16'h002E, 16'h002F, 16'h0000, 16'h002A,
        16'h0000, 16'h0020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4700,
        16'h4800, 16'h4900, 16'h002D, 16'h4B00, 16'h4C00, 16'h4D00, 16'h002B, 16'h4F00,
        16'h5000, 16'h5100, 16'h0030, 16'h002E, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000,
        16'h0000, 16'h001B, 16'h0021, 16'h0040, 16'h0023, 16'h0024, 16'h0025, 16'h005E,
        16'h0026, 16'h002A, 16'h0028, 16'h0029, 16'h005F, 16'h002B, 16'h0008, 16'h0009,
        16'h0051, 16'h0057, 16'h0045, 16'h0052, 16'h0054, 16'h0059, 16'h0055, 16'h0049,
        16'h004F, 16'h0050, 16'h007B, 16'h007D, 16'h000D, 16'h0000, 16'h0041, 16'h0053,
        16'h0044, 16'h0046, 16'h0047, 16'h0048, 16'h004A, 16'h004B, 16'h004C, 16'h003A,
        16'h0022, 16'h007E, 16'h0000, 16'h007C, 16'h005A, 16'h0058, 16'h0043, 16'h0056,
        16'h0042, 16'h004E, 16'h004D, 16'h003C, 16'h003E, 16'h003F, 16'h0000, 16'h002A,
        16'h0000, 16'h0020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0037,
        16'h0038, 16'h0039, 16'h002D, 16'h0034, 16'h0035, 16'h0036, 16'h002B, 16'h0031,
        16'h0032, 16'h0033, 16'h0030, 16'h002E, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000
    };

    localparam logic [7:0] KEYPAD_DIGITS [10] = '{
        8'h47, 8'h48, 8'h49, 8'h4B, 8'h4C, 8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52
    };

    localparam logic [7:0] DIRECTED_CODES [50] = '{
        8'h00, 8'hFF, 8'h3A, 8'h1E, 8'h3A, 8'h2A, 8'h03, 8'hAA, 8'h45, 8'h47,
        8'h45, 8'h36, 8'h44, 8'h58, 8'hB6, 8'h57, 8'h1D, 8'h2E, 8'h02, 8'h9D,
        8'hE0, 8'h1D, 8'hE0, 8'h9D, 8'hE0, 8'h38, 8'hE0, 8'hB8, 8'hE0, 8'h35,
        8'hE0, 8'h1C, 8'hE0, 8'h48, 8'hE0, 8'h2A, 8'hE0, 8'hC8, 8'hE0, 8'hE0,
        8'h48, 8'hE1, 8'h59, 8'h38, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h1E, 8'hB8
    };

    class key_word_tracker;
        logic        prefix_pending = 1'b0;
        logic        caps_latched   = 1'b0;
        logic        num_latched    = 1'b1;
        logic [1:0]  shift_held     = 2'b00;
        logic [1:0]  ctrl_held      = 2'b00;
        logic [1:0]  alt_held       = 2'b00;
        logic [1:0]  digit_count    = 2'b00;
        logic [7:0]  digit_value    = 8'h00;
        logic [15:0] pending_keys[$];
        int          mismatches     = 0;

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function int pending();
            return pending_keys.size();
        endfunction

        function void note_scan_code(logic [7:0] code);
            logic        have;
            logic [15:0] word;
            logic        use_upper;
            logic [15:0] entry;
            logic [7:0]  key_high;
            have = 1'b0;
            word = '0;
            if (prefix_pending) begin
                prefix_pending = 1'b0;
                case (code)
                    SC_CTRL:             ctrl_held[0] = 1'b1;
                    SC_CTRL | BREAK_BIT: ctrl_held[0] = 1'b0;
                    SC_ALT:              alt_held[0] = 1'b1;
                    SC_ALT | BREAK_BIT:  alt_held[0] = 1'b0;
                    SC_KP_SLASH: begin
                        have = 1'b1;
                        word = KEY_SLASH;
                    end
                    SC_KP_ENTER: begin
                        have = 1'b1;
                        word = KEY_CR;
                    end
                    default: begin
                        if (!code[7] && code != SC_LSHIFT) begin
                            have = 1'b1;
                            word = {code, 8'h00};
                        end
                    end
                endcase
            end else begin
                case (code)
                    SC_CAPS:               caps_latched = ~caps_latched;
                    SC_NUM:                num_latched = ~num_latched;
                    SC_LSHIFT:             shift_held[0] = 1'b1;
                    SC_RSHIFT:             shift_held[1] = 1'b1;
                    SC_LSHIFT | BREAK_BIT: shift_held[0] = 1'b0;
                    SC_RSHIFT | BREAK_BIT: shift_held[1] = 1'b0;
                    SC_CTRL:               ctrl_held[1] = 1'b1;
                    SC_CTRL | BREAK_BIT:   ctrl_held[1] = 1'b0;
                    SC_ALT:                alt_held[1] = 1'b1;
                    SC_ALT | BREAK_BIT:    alt_held[1] = 1'b0;
                    default: ;
                endcase
                if (code != SC_E0 && code != SC_E1 && code <= SC_MAX_KEY) begin
                    if (code < SC_KEYPAD)
                        use_upper = (shift_held != 2'b00) != caps_latched;
                    else
                        use_upper = num_latched;
                    if (KEYMAP[int'(code)] != 16'h0000) begin
                        if (alt_held != 2'b00) begin
                            entry = KEYMAP[int'(code) + KEYMAP_HALF];
                            if (code > ALT_MIN_CODE && entry >= "0" && entry <= "9") begin
                                digit_count = digit_count + 2'd1;
                                digit_value = digit_value * 8'd10 + 8'(entry - "0");
                            end
                        end else begin
                            entry = KEYMAP[int'(code) + (use_upper ? KEYMAP_HALF : 0)];
                            have = 1'b1;
                            if (ctrl_held != 2'b00 && entry >= "a" && entry <= "z")
                                word = entry - "a" + 16'd1;
                            else if (ctrl_held != 2'b00 && entry >= "A" && entry <= "Z")
                                word = entry - "A" + 16'd1;
                            else
                                word = entry;
                        end
                    end else if ((code >= SC_F1 && code <= SC_F10) || code == SC_F11
                                 || code == SC_F12) begin
                        if (code >= SC_F11)
                            key_high = code + FKEY_HIGH + (use_upper ? 8'd2 : 8'd0);
                        else
                            key_high = code + (use_upper ? FKEY_SHIFTED : 8'd0);
                        have = 1'b1;
                        word = {key_high, 8'h00};
                    end
                end
            end
            if (code == SC_E0)
                prefix_pending = 1'b1;
            if (digit_count == 2'd3 || (digit_count != 2'd0 && alt_held == 2'b00)) begin
                have = 1'b1;
                word = {8'h00, digit_value};
                digit_count = 2'd0;
                digit_value = 8'h00;
            end
            if (have)
                pending_keys.push_back(word);
        endfunction

        task check_key_word(logic [15:0] got);
            logic [15:0] want;
            if (pending_keys.size() == 0) begin
                report($sformatf("key word %h arrived with none expected", got));
            end else begin
                want = pending_keys.pop_front();
                if (got !== want)
                    report($sformatf("key word %h, expected %h", got, want));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    key_word_tracker tracker;
    int sender_idle_pct = 38;
    int receiver_idle_pct = 68;
    int hold_token = 0;
    int hold_seen = 0;
    int codes_sent = 0;

    scancode_to_key_translator DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    initial begin
        forever begin
            @(negedge clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_key_word(m_tdata);
    end

    task automatic send_code(logic [7:0] code);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge clk); while (!s_tready);
        tracker.note_scan_code(code);
        codes_sent++;
    endtask

    task automatic send_random_burst();
        int         pick;
        int         idx;
        logic [7:0] code;
        logic       right_side;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            code = 8'($urandom_range(1, SC_MAX_KEY));
            send_code(code);
            if ($urandom_range(0, 1))
                send_code(code | BREAK_BIT);
        end else if (pick < 50) begin
            case ($urandom_range(0, 5))
                0: code = SC_LSHIFT;
                1: code = SC_RSHIFT;
                2: code = SC_CTRL;
                3: code = SC_ALT;
                4: code = SC_CAPS;
                default: code = SC_NUM;
            endcase
            if ((code == SC_ALT || code == SC_CTRL) && $urandom_range(0, 1))
                send_code(SC_E0);
            send_code($urandom_range(0, 1) ? code : code | BREAK_BIT);
        end else if (pick < 58) begin
            right_side = $urandom_range(0, 1);
            if (right_side)
                send_code(SC_E0);
            send_code(SC_CTRL);
            idx = $urandom_range(0, 25);
            if (idx < 10)
                code = 8'h10 + 8'(idx);
            else if (idx < 19)
                code = 8'h1E + 8'(idx - 10);
            else
                code = 8'h2C + 8'(idx - 19);
            if ($urandom_range(0, 2) == 0)
                send_code(SC_LSHIFT);
            send_code(code);
            send_code(SC_LSHIFT | BREAK_BIT);
            if (right_side)
                send_code(SC_E0);
            send_code(SC_CTRL | BREAK_BIT);
        end else if (pick < 70) begin
            send_code(SC_E0);
            case ($urandom_range(0, 8))
                0: send_code(SC_CTRL);
                1: send_code(SC_CTRL | BREAK_BIT);
                2: send_code(SC_ALT);
                3: send_code(SC_ALT | BREAK_BIT);
                4: send_code(SC_KP_SLASH);
                5: send_code(SC_KP_ENTER);
                6: send_code(SC_LSHIFT);
                7: send_code(8'($urandom_range(0, 127)));
                default: send_code(8'($urandom_range(0, 255)));
            endcase
        end else if (pick < 82) begin
            right_side = $urandom_range(0, 1);
            if (right_side)
                send_code(SC_E0);
            send_code(SC_ALT);
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 5) == 0)
                    send_code(8'($urandom_range(1, SC_MAX_KEY)));
                else
                    send_code(KEYPAD_DIGITS[$urandom_range(0, 9)]);
            end
            if (right_side)
                send_code(SC_E0);
            send_code(SC_ALT | BREAK_BIT);
        end else if (pick < 90) begin
            idx = $urandom_range(0, 11);
            code = (idx < 10) ? SC_F1 + 8'(idx) : ((idx == 10) ? SC_F11 : SC_F12);
            right_side = $urandom_range(0, 1);
            if (right_side)
                send_code(SC_RSHIFT);
            send_code(code);
            if (right_side)
                send_code(SC_RSHIFT | BREAK_BIT);
        end else begin
            send_code(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        #400000;
        $display("tb_scancode_to_key_translator NOT OK");
        $finish;
    end

    initial begin
        int waited;
        int phase_end;
        tracker = new;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_CODES[i])
            send_code(DIRECTED_CODES[i]);

        phase_end = codes_sent + PHASE_CODES;
        while (codes_sent < phase_end)
            send_random_burst();

        sender_idle_pct = 68;
        receiver_idle_pct = 38;
        phase_end = codes_sent + PHASE_CODES;
        while (codes_sent < phase_end)
            send_random_burst();

        // The receiver stops for a long stretch while requests keep coming.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_token++;
        phase_end = codes_sent + PHASE_CODES;
        while (codes_sent < phase_end)
            send_random_burst();

        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (tracker.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (tracker.pending() > 0)
            tracker.report($sformatf("%0d key words never arrived", tracker.pending()));

        if (tracker.mismatches == 0)
            $display("tb_scancode_to_key_translator OK");
        else
            $display("tb_scancode_to_key_translator NOT OK");
        $finish;
    end

endmodule
